@@ sv/tabular_q_learning_update_core_macros.svh @@
`ifndef TABULAR_Q_LEARNING_UPDATE_CORE_MACROS_SVH
`define TABULAR_Q_LEARNING_UPDATE_CORE_MACROS_SVH

// same-cycle implication, checked on clk_i, off during reset
`define TQLU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i, off during reset
`define TQLU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tqlu_pkg.sv @@
`timescale 1ns / 1ps

package tqlu_pkg;

  localparam int NUM_OBS     = 3;
  localparam int NUM_ACTIONS = 3;
  localparam int NUM_ENTRIES = NUM_OBS * NUM_ACTIONS;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);

  localparam int FUNC_W  = 2;
  localparam int ACT_W   = 2;
  localparam int OBS_W   = 2;
  localparam int RWD_W   = 16;
  localparam int VAL_W   = 24;
  localparam int FRAC_W  = 16;

  localparam int TGT_W   = VAL_W + 1;
  localparam int DIFF_W  = VAL_W + 2;
  localparam int PROD_W  = FRAC_W + 1 + DIFF_W;
  localparam int FRAC_SHIFT = 16;
  localparam int STEP_W  = PROD_W - FRAC_SHIFT;
  localparam int NV_W    = STEP_W + 1;
  localparam int ROUND_HALF = 32768;

  localparam int VAL_MAX = 8388607;
  localparam int VAL_MIN = -8388608;

  localparam logic [FRAC_W-1:0] DISCOUNT_RST = 16'd62259;
  localparam logic [FRAC_W-1:0] LEARN_RST    = 16'd55706;

  localparam int CFG_IDX_W = 1;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;

  // input tdata field positions
  localparam int IN_ACT_LSB   = 0;
  localparam int IN_RWD_LSB   = IN_ACT_LSB + ACT_W;
  localparam int IN_NOBS_LSB  = IN_RWD_LSB + RWD_W;
  localparam int IN_EXPL_LSB  = IN_NOBS_LSB + OBS_W;
  localparam int IN_RACT_LSB  = IN_EXPL_LSB + 1;
  localparam int IN_ROW_LSB   = IN_RACT_LSB + ACT_W;
  localparam int IN_COL_LSB   = IN_ROW_LSB + OBS_W;
  localparam int IN_EVAL_LSB  = IN_COL_LSB + ACT_W;
  localparam int IN_USED_W    = IN_EVAL_LSB + VAL_W;
  localparam int OUT_USED_W   = ACT_W + VAL_W + OBS_W + 1;

  typedef enum logic [FUNC_W-1:0] {
    FN_TRANSITION = 2'd0,
    FN_LOAD       = 2'd1,
    FN_START      = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISCOUNT = 1'd0,
    CFG_LEARN    = 1'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAX,
    ST_MUL_G,
    ST_DIFF,
    ST_MUL_A,
    ST_WRITE,
    ST_APPLY,
    ST_SCAN,
    ST_DONE
  } tqlu_state_e;

  typedef struct packed {
    logic                    en;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] data;
  } tbl_wr_t;

  function automatic logic [IDX_W-1:0] entry_idx(logic [OBS_W-1:0] row,
                                                 logic [ACT_W-1:0] col);
    entry_idx = IDX_W'(row) * IDX_W'(NUM_ACTIONS) + IDX_W'(col);
  endfunction

  // round half up to Q16.8: add half an LSB, floor shift
  function automatic logic signed [STEP_W-1:0] round_q16(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + PROD_W'(ROUND_HALF);
    round_q16 = STEP_W'(s >>> FRAC_SHIFT);
  endfunction

endpackage

@@ sv/tqlu_mul.sv @@
`timescale 1ns / 1ps

module tqlu_mul
  import tqlu_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [FRAC_W-1:0]        frac_i,
  input  logic signed [DIFF_W-1:0] opnd_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;

  assign prod_d = PROD_W'($signed({1'b0, frac_i})) * PROD_W'(opnd_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ sv/tqlu_table.sv @@
`timescale 1ns / 1ps

module tqlu_table
  import tqlu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tbl_wr_t                 wr_i,
  input  logic [IDX_W-1:0]        rd_idx_i,
  output logic signed [VAL_W-1:0] rd_data_o
);

  logic signed [VAL_W-1:0] val_q [NUM_ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        val_q[i] <= '0;
      end
    end else if (wr_i.en && (wr_i.idx < IDX_W'(NUM_ENTRIES))) begin
      val_q[wr_i.idx] <= wr_i.data;
    end
  end

  assign rd_data_o = (rd_idx_i < IDX_W'(NUM_ENTRIES)) ? val_q[rd_idx_i] : '0;

endmodule

@@ sv/tabular_q_learning_update_core.sv @@
`timescale 1ns / 1ps

// Tabular Q-learning update core.
// Input stream s_axis: one request per item, func in tuser selects a transition
// update, a table entry load or an episode start. Output stream m_axis: one
// result per request with the next action, the written value, the held
// observation and the clip flag. Config port: cfg_we_i writes discount (0) or
// learning rate (1) from cfg_wdata_i; write only while idle.
// Sequence: a non-terminal transition scans the successor row for its maximum,
// scales it by the discount, forms the difference, scales that by the learning
// rate, writes the entry and scans the held row for the greedy action; a terminal
// one skips the first scan; a load, an episode start or an ignored request only
// applies and scans. The pace is set by the single table read port (three entries
// per row scan) and the one shared multiplier used twice in sequence.
// Next request is taken as soon as the sequencer is back in idle, even while the
// previous result still waits in the output register; a stalled receiver only
// holds the sequencer at its final step until the register frees.
// Reset clears the table to zero, the observation to 0 and restores the
// default discount and learning rate.

`include "tabular_q_learning_update_core_macros.svh"

module tabular_q_learning_update_core
  import tqlu_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // taken_action, reward, next_obs, explore, random_action, entry_row,
  // entry_col, entry_value
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // func
  input  logic [FUNC_W-1:0]      s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // next_action, updated_value, current_obs, saturated
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [FRAC_W-1:0]      cfg_wdata_i
);

  tqlu_state_e state_q, state_d;

  logic [FRAC_W-1:0] discount_q, learn_q;
  logic [OBS_W-1:0]  held_obs_q, held_obs_d;
  logic [ACT_W-1:0]  scan_col_q, scan_col_d;
  logic              out_valid_q, out_valid_d;
  logic              out_load;

  logic [FUNC_W-1:0]       func_q;
  logic [ACT_W-1:0]        act_q;
  logic signed [RWD_W-1:0] reward_q;
  logic [OBS_W-1:0]        nobs_q;
  logic                    explore_q;
  logic [ACT_W-1:0]        ract_q;
  logic [OBS_W-1:0]        row_q;
  logic [ACT_W-1:0]        col_q;
  logic signed [VAL_W-1:0] eval_q;

  logic signed [VAL_W-1:0]  best_q, best_d;
  logic [ACT_W-1:0]         best_idx_q, best_idx_d;
  logic signed [VAL_W-1:0]  old_q, old_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic signed [VAL_W-1:0]  upd_q, upd_d;
  logic                     sat_q, sat_d;

  logic [ACT_W-1:0]        o_act_q;
  logic signed [VAL_W-1:0] o_upd_q;
  logic [OBS_W-1:0]        o_obs_q;
  logic                    o_sat_q;

  logic                     accept;
  tbl_wr_t                  tbl_wr;
  logic [IDX_W-1:0]         rd_idx;
  logic signed [VAL_W-1:0]  rd_data;
  logic                     mul_en;
  logic                     mul_gamma;
  logic [FRAC_W-1:0]        mul_frac;
  logic signed [DIFF_W-1:0] mul_opnd;
  logic signed [PROD_W-1:0] prod;
  logic signed [STEP_W-1:0] step;
  logic signed [TGT_W-1:0]  target;
  logic signed [NV_W-1:0]   nv;
  logic                     scan_last;
  logic                     scan_better;
  logic [ACT_W-1:0]         nact;

  tqlu_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tbl_wr),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data)
  );

  assign mul_frac = mul_gamma ? discount_q : learn_q;
  assign mul_opnd = mul_gamma ? DIFF_W'(best_q) : diff_q;

  tqlu_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .frac_i (mul_frac),
    .opnd_i (mul_opnd),
    .prod_o (prod)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign step        = round_q16(prod);
  assign target      = TGT_W'(reward_q) + $signed(step[TGT_W-1:0]);
  assign nv          = NV_W'(old_q) + NV_W'(step);
  assign scan_last   = (scan_col_q == ACT_W'(NUM_ACTIONS - 1));
  assign scan_better = (scan_col_q == '0) || (rd_data > best_q);
  assign nact        = (explore_q && (ract_q < ACT_W'(NUM_ACTIONS))) ? ract_q : best_idx_q;

  always_comb begin
    state_d     = state_q;
    held_obs_d  = held_obs_q;
    scan_col_d  = scan_col_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    old_d       = old_q;
    diff_d      = diff_q;
    upd_d       = upd_q;
    sat_d       = sat_q;
    mul_en      = 1'b0;
    mul_gamma   = 1'b1;
    out_load    = 1'b0;
    tbl_wr      = '0;
    rd_idx      = entry_idx(held_obs_q, act_q);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          scan_col_d = '0;
          best_d     = '0;
          upd_d      = '0;
          sat_d      = 1'b0;
          if ((s_axis_tuser_i == FN_TRANSITION) &&
              (s_axis_tdata_i[IN_ACT_LSB +: ACT_W] < ACT_W'(NUM_ACTIONS))) begin
            if (s_axis_tdata_i[IN_NOBS_LSB +: OBS_W] < OBS_W'(NUM_OBS)) begin
              state_d = ST_MAX;
            end else begin
              state_d = ST_MUL_G;
            end
          end else begin
            state_d = ST_APPLY;
          end
        end
      end
      ST_MAX: begin
        rd_idx = entry_idx(nobs_q, scan_col_q);
        if (scan_better) begin
          best_d = rd_data;
        end
        scan_col_d = scan_col_q + 1'b1;
        if (scan_last) begin
          scan_col_d = '0;
          state_d    = ST_MUL_G;
        end
      end
      ST_MUL_G: begin
        mul_en  = 1'b1;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        old_d   = rd_data;
        diff_d  = DIFF_W'(target) - DIFF_W'(rd_data);
        state_d = ST_MUL_A;
      end
      ST_MUL_A: begin
        mul_en    = 1'b1;
        mul_gamma = 1'b0;
        state_d   = ST_WRITE;
      end
      ST_WRITE: begin
        if (nv > NV_W'(VAL_MAX)) begin
          upd_d = VAL_W'(VAL_MAX);
          sat_d = 1'b1;
        end else if (nv < NV_W'(VAL_MIN)) begin
          upd_d = VAL_W'(VAL_MIN);
          sat_d = 1'b1;
        end else begin
          upd_d = nv[VAL_W-1:0];
        end
        tbl_wr.en   = 1'b1;
        tbl_wr.idx  = entry_idx(held_obs_q, act_q);
        tbl_wr.data = upd_d;
        if (nobs_q < OBS_W'(NUM_OBS)) begin
          held_obs_d = nobs_q;
        end
        state_d = ST_SCAN;
      end
      ST_APPLY: begin
        case (func_q)
          FN_LOAD: begin
            if ((row_q < OBS_W'(NUM_OBS)) && (col_q < ACT_W'(NUM_ACTIONS))) begin
              tbl_wr.en   = 1'b1;
              tbl_wr.idx  = entry_idx(row_q, col_q);
              tbl_wr.data = eval_q;
              upd_d       = eval_q;
            end
          end
          FN_START: begin
            held_obs_d = '0;
          end
          default: begin
          end
        endcase
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        rd_idx = entry_idx(held_obs_q, scan_col_q);
        if (scan_better) begin
          best_d     = rd_data;
          best_idx_d = scan_col_q;
        end
        scan_col_d = scan_col_q + 1'b1;
        if (scan_last) begin
          scan_col_d = '0;
          state_d    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_obs_q  <= '0;
      scan_col_q  <= '0;
      out_valid_q <= 1'b0;
      discount_q  <= DISCOUNT_RST;
      learn_q     <= LEARN_RST;
    end else begin
      state_q     <= state_d;
      held_obs_q  <= held_obs_d;
      scan_col_q  <= scan_col_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DISCOUNT: discount_q <= cfg_wdata_i;
          CFG_LEARN:    learn_q    <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= s_axis_tuser_i;
      act_q     <= s_axis_tdata_i[IN_ACT_LSB +: ACT_W];
      reward_q  <= s_axis_tdata_i[IN_RWD_LSB +: RWD_W];
      nobs_q    <= s_axis_tdata_i[IN_NOBS_LSB +: OBS_W];
      explore_q <= s_axis_tdata_i[IN_EXPL_LSB];
      ract_q    <= s_axis_tdata_i[IN_RACT_LSB +: ACT_W];
      row_q     <= s_axis_tdata_i[IN_ROW_LSB +: OBS_W];
      col_q     <= s_axis_tdata_i[IN_COL_LSB +: ACT_W];
      eval_q    <= s_axis_tdata_i[IN_EVAL_LSB +: VAL_W];
    end
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    old_q      <= old_d;
    diff_q     <= diff_d;
    upd_q      <= upd_d;
    sat_q      <= sat_d;
    if (out_load) begin
      o_act_q <= nact;
      o_upd_q <= upd_q;
      o_obs_q <= held_obs_q;
      o_sat_q <= sat_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - OUT_USED_W)'(0), o_sat_q, o_obs_q, o_upd_q, o_act_q};

  `TQLU_ASSERT_NOW(a_held_obs_range, 1'b1, held_obs_q < OBS_W'(NUM_OBS),
    "held observation out of range")
  `TQLU_ASSERT_NOW(a_write_state, tbl_wr.en,
    (state_q == ST_WRITE) || (state_q == ST_APPLY), "table write outside an update step")
  `TQLU_ASSERT_NOW(a_sat_extreme, out_valid_q && o_sat_q,
    (o_upd_q == VAL_W'(VAL_MAX)) || (o_upd_q == VAL_W'(VAL_MIN)),
    "clip flag without a clipped value")
  `TQLU_ASSERT_NEXT(a_done_hold, (state_q == ST_DONE) && out_valid_q && !m_axis_tready_i,
    state_q == ST_DONE, "result dropped while output register full")

endmodule
